// ----- rtl/tile_bounding_box_tracker_macros.svh -----
// Assertion macros shared by the tile bounding box tracker checkers.
`ifndef TILE_BOUNDING_BOX_TRACKER_MACROS_SVH
`define TILE_BOUNDING_BOX_TRACKER_MACROS_SVH

// Check that cons holds in the cycle after ante, outside reset.
`define TBBT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbbt checker: property failed");

// Check that cons holds in the cycle after ante, also across reset.
`define TBBT_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tbbt checker: property failed");

`endif

// ----- rtl/tbbt_pkg.sv -----
// Shared types and constants of the tile bounding box tracker.
package tbbt_pkg;

  localparam int FIELD_W   = 32;
  localparam int DIM_SLOTS = 4;
  localparam int IDX_W     = 2;
  localparam int DIMS_W    = 3;
  localparam int CFG_IDX_W = 2;

  localparam int DEF_MAX_DIMS    = 4;
  localparam int DEF_COORD_WIDTH = 32;

  localparam logic [FIELD_W-1:0] CAPACITY_RESET = 32'd10000;
  localparam logic [DIMS_W-1:0]  DIMS_RESET     = 3'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DIMS     = 2'd1;

  typedef struct packed {
    logic [FIELD_W-1:0] low;
    logic [FIELD_W-1:0] high;
    logic [FIELD_W-1:0] first;
    logic [FIELD_W-1:0] last;
  } dim_rec_t;

  typedef struct packed {
    logic             load;
    logic [IDX_W-1:0] last_idx;
  } emit_ctl_t;

  typedef struct packed {
    logic free;
  } emit_sts_t;

endpackage

// ----- rtl/tbbt_lane.sv -----
// One dimension's bounding box, first and last coordinate of the open tile.
module tbbt_lane #(
  parameter int COORD_WIDTH = tbbt_pkg::DEF_COORD_WIDTH
) (
  input  logic                                clk,
  input  logic                                upd,
  input  logic                                start,
  input  logic signed [tbbt_pkg::FIELD_W-1:0] coord_in,
  output tbbt_pkg::dim_rec_t                  rec_nxt
);

  logic signed [COORD_WIDTH-1:0] c;
  logic signed [COORD_WIDTH-1:0] low_r, low_nxt;
  logic signed [COORD_WIDTH-1:0] high_r, high_nxt;
  logic signed [COORD_WIDTH-1:0] first_r, first_nxt;
  logic signed [COORD_WIDTH-1:0] last_r, last_nxt;

  assign c = COORD_WIDTH'(coord_in);

  always_comb begin
    low_nxt   = low_r;
    high_nxt  = high_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    if (upd) begin
      last_nxt = c;
      if (start) begin
        low_nxt   = c;
        high_nxt  = c;
        first_nxt = c;
      end else begin
        if (c < low_r) begin
          low_nxt = c;
        end
        if (c > high_r) begin
          high_nxt = c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    low_r   <= low_nxt;
    high_r  <= high_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
  end

  assign rec_nxt.low   = tbbt_pkg::FIELD_W'($unsigned(low_nxt));
  assign rec_nxt.high  = tbbt_pkg::FIELD_W'($unsigned(high_nxt));
  assign rec_nxt.first = tbbt_pkg::FIELD_W'($unsigned(first_nxt));
  assign rec_nxt.last  = tbbt_pkg::FIELD_W'($unsigned(last_nxt));

endmodule

// ----- rtl/tbbt_emit.sv -----
// Result buffer that plays out one beat per reported dimension of a closed tile.
module tbbt_emit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tbbt_pkg::emit_ctl_t               ctl,
  input  tbbt_pkg::dim_rec_t                snap [tbbt_pkg::DIM_SLOTS],
  input  logic [tbbt_pkg::FIELD_W-1:0]      snap_count,
  output tbbt_pkg::emit_sts_t               sts,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [tbbt_pkg::IDX_W-1:0]        out_dim_index,
  output logic signed [tbbt_pkg::FIELD_W-1:0] out_bound_low,
  output logic signed [tbbt_pkg::FIELD_W-1:0] out_bound_high,
  output logic signed [tbbt_pkg::FIELD_W-1:0] out_first_coord,
  output logic signed [tbbt_pkg::FIELD_W-1:0] out_last_coord,
  output logic [tbbt_pkg::FIELD_W-1:0]      out_cell_count,
  output logic                              out_last_of_tile
);

  logic                            busy_r, busy_nxt;
  logic [tbbt_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic [tbbt_pkg::IDX_W-1:0]      last_idx_r;
  logic [tbbt_pkg::FIELD_W-1:0]    count_r;
  tbbt_pkg::dim_rec_t              rec_r [tbbt_pkg::DIM_SLOTS];
  logic                            fire;
  logic                            done;

  assign fire     = busy_r & ~out_stall;
  assign done     = fire & (idx_r == last_idx_r);
  assign sts.free = ~busy_r | done;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (ctl.load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (fire) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      last_idx_r <= ctl.last_idx;
      count_r    <= snap_count;
      rec_r      <= snap;
    end
  end

  assign out_valid        = busy_r;
  assign out_dim_index    = idx_r;
  assign out_bound_low    = rec_r[idx_r].low;
  assign out_bound_high   = rec_r[idx_r].high;
  assign out_first_coord  = rec_r[idx_r].first;
  assign out_last_coord   = rec_r[idx_r].last;
  assign out_cell_count   = count_r;
  assign out_last_of_tile = (idx_r == last_idx_r);

endmodule

// ----- rtl/tile_bounding_box_tracker.sv -----
// Top level of the tile bounding box tracker.
// Input channel: one beat per cell (in_cmd = 0, coordinates on in_coord_0..3)
//   or a flush (in_cmd = 1, coordinates ignored); in_valid / in_stall.
// Result channel: one beat per reported dimension of a closed tile, in
//   dimension order, out_last_of_tile on the final beat; out_valid / out_stall.
// Config channel: cfg_valid / cfg_ready, cfg_index 0 = tile capacity,
//   1 = dimensions in use; cfg_ready is always high. Write only while idle.
// Throughput: one cell per cycle while in_stall is low. The lane registers fold
//   each cell in the cycle it is taken; a closing cell or a flush of a non-empty
//   tile copies the tile into the result buffer, whose first beat shows the next cycle.
// A tile plays out over one to four beats from the single result buffer;
//   cells keep flowing meanwhile, and only a beat that closes another tile
//   while the buffer still holds the previous one is stalled.
// Reset clears the cell count, empties the result buffer and sets the registers to
//   capacity 10000 and two dimensions. A stall on the result side holds the
//   current beat and, once a second tile closes, backs up the input.
module tile_bounding_box_tracker #(
  parameter int MAX_DIMS    = tbbt_pkg::DEF_MAX_DIMS,
  parameter int COORD_WIDTH = tbbt_pkg::DEF_COORD_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic signed [tbbt_pkg::FIELD_W-1:0]   in_coord_0,
  input  logic signed [tbbt_pkg::FIELD_W-1:0]   in_coord_1,
  input  logic signed [tbbt_pkg::FIELD_W-1:0]   in_coord_2,
  input  logic signed [tbbt_pkg::FIELD_W-1:0]   in_coord_3,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [tbbt_pkg::IDX_W-1:0]            out_dim_index,
  output logic signed [tbbt_pkg::FIELD_W-1:0]   out_bound_low,
  output logic signed [tbbt_pkg::FIELD_W-1:0]   out_bound_high,
  output logic signed [tbbt_pkg::FIELD_W-1:0]   out_first_coord,
  output logic signed [tbbt_pkg::FIELD_W-1:0]   out_last_coord,
  output logic [tbbt_pkg::FIELD_W-1:0]          out_cell_count,
  output logic                                  out_last_of_tile,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tbbt_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tbbt_pkg::FIELD_W-1:0]          cfg_data
);

  localparam logic [tbbt_pkg::DIMS_W-1:0] MaxDimsW = tbbt_pkg::DIMS_W'(MAX_DIMS);

  logic [tbbt_pkg::FIELD_W-1:0] capacity_r;
  logic [tbbt_pkg::DIMS_W-1:0]  dims_r;
  logic [tbbt_pkg::FIELD_W-1:0] cnt_r, cnt_nxt;
  logic [tbbt_pkg::FIELD_W-1:0] cnt_inc;
  logic                         tile_empty;
  logic                         closes;
  logic                         accept;
  logic                         upd;
  logic [tbbt_pkg::DIMS_W-1:0]  n_minus1;

  logic signed [tbbt_pkg::FIELD_W-1:0] coord [tbbt_pkg::DIM_SLOTS];
  tbbt_pkg::dim_rec_t                  snap [tbbt_pkg::DIM_SLOTS];
  tbbt_pkg::emit_ctl_t                 ctl;
  tbbt_pkg::emit_sts_t                 sts;

  assign coord[0] = in_coord_0;
  assign coord[1] = in_coord_1;
  assign coord[2] = in_coord_2;
  assign coord[3] = in_coord_3;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= tbbt_pkg::CAPACITY_RESET;
      dims_r     <= tbbt_pkg::DIMS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tbbt_pkg::CFG_IDX_CAPACITY: capacity_r <= cfg_data;
        tbbt_pkg::CFG_IDX_DIMS:     dims_r     <= cfg_data[tbbt_pkg::DIMS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cnt_inc    = cnt_r + 1'b1;
  assign tile_empty = (cnt_r == '0);
  assign closes     = in_cmd ? ~tile_empty : (cnt_inc == capacity_r);
  assign in_stall   = closes & ~sts.free;
  assign accept     = in_valid & ~in_stall;
  assign upd        = accept & ~in_cmd;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (closes || in_cmd) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_comb begin
    if (dims_r == '0) begin
      n_minus1 = '0;
    end else if (dims_r > MaxDimsW) begin
      n_minus1 = MaxDimsW - 1'b1;
    end else begin
      n_minus1 = dims_r - 1'b1;
    end
  end

  assign ctl.load     = accept & closes;
  assign ctl.last_idx = n_minus1[tbbt_pkg::IDX_W-1:0];

  for (genvar d = 0; d < tbbt_pkg::DIM_SLOTS; d++) begin : g_lane
    if (d < MAX_DIMS) begin : g_used
      tbbt_lane #(
        .COORD_WIDTH (COORD_WIDTH)
      ) u_lane (
        .clk      (clk),
        .upd      (upd),
        .start    (tile_empty),
        .coord_in (coord[d]),
        .rec_nxt  (snap[d])
      );
    end else begin : g_unused
      assign snap[d] = '0;
    end
  end

  tbbt_emit u_emit (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .snap             (snap),
    .snap_count       (in_cmd ? cnt_r : cnt_inc),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_dim_index    (out_dim_index),
    .out_bound_low    (out_bound_low),
    .out_bound_high   (out_bound_high),
    .out_first_coord  (out_first_coord),
    .out_last_coord   (out_last_coord),
    .out_cell_count   (out_cell_count),
    .out_last_of_tile (out_last_of_tile)
  );

endmodule

// ----- rtl/tbbt_checker.sv -----
// Port-level checks of the tile bounding box tracker and their bind.
`include "tile_bounding_box_tracker_macros.svh"

module tbbt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [tbbt_pkg::IDX_W-1:0]   out_dim_index,
  input logic                         out_last_of_tile
);

  `TBBT_ASSERT_NEXT(a_stall_holds_valid, out_valid && out_stall, out_valid)
  `TBBT_ASSERT_NEXT(a_stall_holds_beat, out_valid && out_stall,
                    $stable(out_dim_index) && $stable(out_last_of_tile))
  `TBBT_ASSERT_NEXT(a_burst_continues, out_valid && !out_stall && !out_last_of_tile,
                    out_valid)
  `TBBT_ASSERT_NEXT(a_dim_advances, out_valid && !out_stall && !out_last_of_tile,
                    out_dim_index == $past(out_dim_index) + 2'd1)
  `TBBT_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_valid)

endmodule

bind tile_bounding_box_tracker tbbt_checker u_tbbt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_dim_index    (out_dim_index),
  .out_last_of_tile (out_last_of_tile)
);
